// File: sv/tcc_pkg.sv
package tcc_pkg;

    localparam int MAX_TAPS = 6;
    localparam int DOTS_W = 6;
    localparam int CNT_W = 5;
    localparam logic [DOTS_W-1:0] DOTS_MAX = 6'd63;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_K = 8'h6B;
    localparam logic [7:0] CH_LOW_C = 8'h63;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_TAPS = 2'd1;

    localparam logic [7:0] SQUARE [25] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65,
        8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
        8'h71, 8'h72, 8'h73, 8'h74, 8'h75,
        8'h76, 8'h77, 8'h78, 8'h79, 8'h7A
    };

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_DOT,
        SEL_SPACE,
        SEL_SPACE_LAST,
        SEL_LETTER
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load_row;
        logic     load_col;
        logic     cnt_dec;
        out_sel_t emit;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic is_letter;
        logic is_dot;
        logic in_column;
        logic slot_free;
        logic cnt_one;
    } status_t;

    function automatic logic [2:0] pos_row(input logic [4:0] idx);
        logic [2:0] r;
        if (idx < 5'd5) r = 3'd1;
        else if (idx < 5'd10) r = 3'd2;
        else if (idx < 5'd15) r = 3'd3;
        else if (idx < 5'd20) r = 3'd4;
        else r = 3'd5;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] idx);
        logic [4:0] base;
        logic [4:0] diff;
        base = 5'(({2'b00, pos_row(idx)} - 5'd1) * 5'd5);
        diff = idx - base;
        return 3'(diff + 5'd1);
    endfunction

    // Quotient of a dot count by the tap multiplier, saturating at MAX_TAPS.
    function automatic logic [2:0] tap_quot(input logic [DOTS_W-1:0] n, input logic [2:0] t);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= MAX_TAPS; k++) begin
            if ({1'b0, n} >= 7'(7'(k) * {4'b0000, t})) begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

endpackage

// File: sv/tcc_datapath.sv
module tcc_datapath
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_data,
    input  logic [7:0]  in_char,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last,
    output logic        error
);

    logic              mode_reg;
    logic [2:0]        taps_reg;
    logic [2:0]        taps_next;
    logic [DOTS_W-1:0] row_dots_reg;
    logic [DOTS_W-1:0] row_dots_next;
    logic [DOTS_W-1:0] col_dots_reg;
    logic [DOTS_W-1:0] col_dots_next;
    logic              in_column_reg;
    logic              in_column_next;
    logic [CNT_W-1:0]  dot_cnt_reg;
    logic [CNT_W-1:0]  dot_cnt_next;
    logic [2:0]        enc_col_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_char_reg;
    logic [7:0]        out_char_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_error_reg;
    logic              out_error_next;

    logic [7:0] lower_ch;
    logic [7:0] folded_ch;
    logic [4:0] letter_idx;
    logic [4:0] raw_idx;
    logic [2:0] enc_row;
    logic [2:0] enc_col;
    logic [2:0] dec_row;
    logic [2:0] dec_col;
    logic       dec_ok;
    logic [4:0] sq_idx;
    logic       slot_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        lower_ch = in_char;
        if (in_char inside {[CH_UP_A:CH_UP_Z]}) begin
            lower_ch = in_char + CASE_OFFSET;
        end
        folded_ch = (lower_ch == CH_LOW_K) ? CH_LOW_C : lower_ch;
        raw_idx = 5'(folded_ch - CH_LOW_A);
        letter_idx = (raw_idx > 5'd10) ? raw_idx - 5'd1 : raw_idx;
        enc_row = pos_row(letter_idx);
        enc_col = pos_col(letter_idx);
    end

    always_comb
    begin
        dec_row = tap_quot(row_dots_reg, taps_reg);
        dec_col = tap_quot(col_dots_reg, taps_reg);
        dec_ok = (dec_row inside {[3'd1:3'd5]}) && (dec_col inside {[3'd1:3'd5]});
        sq_idx = 5'(({2'b00, dec_row} - 5'd1) * 5'd5 + {2'b00, dec_col} - 5'd1);
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.mode = mode_reg;
        status.is_letter = lower_ch inside {[CH_LOW_A:CH_LOW_Z]};
        status.is_dot = (in_char == CH_DOT);
        status.in_column = in_column_reg;
        status.slot_free = slot_free;
        status.cnt_one = (dot_cnt_reg == CNT_W'(1));
    end

    always_comb
    begin
        taps_next = cfg_data[2:0];
        if (taps_next == 3'd0) taps_next = 3'd1;
        if (taps_next > 3'(MAX_TAPS)) taps_next = 3'(MAX_TAPS);
    end

    always_comb
    begin
        row_dots_next = row_dots_reg;
        col_dots_next = col_dots_reg;
        in_column_next = in_column_reg;
        if (cmd.accept && mode_reg) begin
            if (in_char == CH_DOT) begin
                if (!in_column_reg && row_dots_reg != DOTS_MAX) begin
                    row_dots_next = row_dots_reg + DOTS_W'(1);
                end
                if (in_column_reg && col_dots_reg != DOTS_MAX) begin
                    col_dots_next = col_dots_reg + DOTS_W'(1);
                end
            end else if (!in_column_reg) begin
                in_column_next = 1'b1;
            end
        end
        if (cmd.emit == SEL_LETTER) begin
            row_dots_next = '0;
            col_dots_next = '0;
            in_column_next = 1'b0;
        end
    end

    always_comb
    begin
        dot_cnt_next = dot_cnt_reg;
        if (cmd.load_row) begin
            dot_cnt_next = CNT_W'(enc_row * taps_reg);
        end else if (cmd.load_col) begin
            dot_cnt_next = CNT_W'(enc_col_reg * taps_reg);
        end else if (cmd.cnt_dec) begin
            dot_cnt_next = dot_cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_error_next = out_error_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (cmd.emit)
            SEL_NONE:
            begin
            end
            SEL_DOT:
            begin
                out_char_next = CH_DOT;
                out_last_next = 1'b0;
                out_error_next = 1'b0;
                out_valid_next = 1'b1;
            end
            SEL_SPACE:
            begin
                out_char_next = CH_SPACE;
                out_last_next = 1'b0;
                out_error_next = 1'b0;
                out_valid_next = 1'b1;
            end
            SEL_SPACE_LAST:
            begin
                out_char_next = CH_SPACE;
                out_last_next = 1'b1;
                out_error_next = 1'b0;
                out_valid_next = 1'b1;
            end
            SEL_LETTER:
            begin
                out_char_next = dec_ok ? SQUARE[sq_idx] : 8'h00;
                out_last_next = 1'b1;
                out_error_next = !dec_ok;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
            taps_reg <= 3'd1;
            row_dots_reg <= '0;
            col_dots_reg <= '0;
            in_column_reg <= 1'b0;
            dot_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_addr == REG_MODE) mode_reg <= cfg_data[0];
            if (cfg_valid && cfg_addr == REG_TAPS) taps_reg <= taps_next;
            row_dots_reg <= row_dots_next;
            col_dots_reg <= col_dots_next;
            in_column_reg <= in_column_next;
            dot_cnt_reg <= dot_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row) enc_col_reg <= enc_col;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_error_reg <= out_error_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign last = out_last_reg;
    assign error = out_error_reg;

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != SEL_NONE) |-> slot_free)
        else $error("Result loaded while the output register is still occupied.");

    a_dot_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit == SEL_DOT) |-> (dot_cnt_reg != '0))
        else $error("Dot emitted with an empty dot counter.");

    a_letter_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit == SEL_LETTER) |=> (row_dots_reg == '0 && col_dots_reg == '0 && !in_column_reg))
        else $error("Decode counts not cleared after a letter.");

endmodule

// File: sv/tcc_ctrl.sv
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ROW_DOTS = 6'b000010,
        ST_ROW_SP   = 6'b000100,
        ST_COL_DOTS = 6'b001000,
        ST_COL_SP   = 6'b010000,
        ST_DEC_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.load_row = 1'b0;
        cmd.load_col = 1'b0;
        cmd.cnt_dec = 1'b0;
        cmd.emit = SEL_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    if (!status.mode && status.is_letter) begin
                        cmd.load_row = 1'b1;
                        state_next = ST_ROW_DOTS;
                    end else if (status.mode && !status.is_dot && status.in_column) begin
                        state_next = ST_DEC_OUT;
                    end
                end
            end
            ST_ROW_DOTS:
            begin
                if (status.slot_free) begin
                    cmd.emit = SEL_DOT;
                    cmd.cnt_dec = 1'b1;
                    if (status.cnt_one) state_next = ST_ROW_SP;
                end
            end
            ST_ROW_SP:
            begin
                if (status.slot_free) begin
                    cmd.emit = SEL_SPACE;
                    cmd.load_col = 1'b1;
                    state_next = ST_COL_DOTS;
                end
            end
            ST_COL_DOTS:
            begin
                if (status.slot_free) begin
                    cmd.emit = SEL_DOT;
                    cmd.cnt_dec = 1'b1;
                    if (status.cnt_one) state_next = ST_COL_SP;
                end
            end
            ST_COL_SP:
            begin
                if (status.slot_free) begin
                    cmd.emit = SEL_SPACE_LAST;
                    state_next = ST_IDLE;
                end
            end
            ST_DEC_OUT:
            begin
                if (status.slot_free) begin
                    cmd.emit = SEL_LETTER;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_letter_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && !status.mode && status.is_letter)
        |=> (state_reg == ST_ROW_DOTS))
        else $error("Accepted letter did not start a dot run.");

    a_run_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COL_SP && status.slot_free) |=> (state_reg == ST_IDLE))
        else $error("Final space did not return the controller to idle.");

endmodule

// File: sv/tap_code_codec.sv
// Encode: an accepted letter loads the dot counter and enters the row-dot state, then
// emits row*T + col*T + 2 results at one per cycle while the output slot is free; the
// next item is taken once the controller is back in idle after the last is loaded.
// Decode: dots and the first separator are taken in idle; the closing separator moves
// to the decode-output state, which loads its letter once the output slot is free.
// Asynchronous active-low reset: encode, T = 1, counts cleared.
module tap_code_codec
    import tcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last,
    output logic       error
);

    cmd_t    cmd;
    status_t status;

    tcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_char   (in_char),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last),
        .error     (error)
    );

endmodule
